[design/pcd_pkg.sv]
// Package for the percent escape decoder: constants, types and hex helpers.
package pcd_pkg;

  localparam int BYTE_W = 8;
  localparam int CNT_W  = 13;

  localparam logic [BYTE_W-1:0] PCT_CHAR  = 8'h25;
  localparam logic [BYTE_W-1:0] DOT_CHAR  = 8'h2E;
  localparam logic [BYTE_W-1:0] NUL_CHAR  = 8'h00;
  localparam logic [CNT_W-1:0]  MAX_RESET = 13'd1024;

  localparam logic [1:0] STAGE_IDLE  = 2'd0;
  localparam logic [1:0] STAGE_PCT   = 2'd1;
  localparam logic [1:0] STAGE_DIGIT = 2'd2;

  typedef logic [2:0][BYTE_W-1:0] slots_t;

  // Results produced by one input beat, slot 0 goes out first.
  typedef struct packed {
    logic [1:0] cnt;
    logic       term;
    slots_t     data;
  } pcd_burst_t;

  function automatic logic hex_ok(input logic [BYTE_W-1:0] b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46) ||
           (b >= 8'h61 && b <= 8'h66);
  endfunction

  function automatic logic [3:0] hex_val(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] t;
    if (b <= 8'h39) begin
      t = b - 8'h30;
    end else if (b <= 8'h46) begin
      t = b - 8'h37;
    end else begin
      t = b - 8'h57;
    end
    return t[3:0];
  endfunction

endpackage

[design/pcd_core.sv]
// Escape parser state, output length limit and per-beat result burst.
module pcd_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           accept,
  input  logic [pcd_pkg::BYTE_W-1:0]     in_byte,
  input  logic [pcd_pkg::CNT_W-1:0]      max_out_len,
  output pcd_pkg::pcd_burst_t            burst
);

  logic [1:0]                    stage;
  logic [1:0]                    stage_next;
  logic [pcd_pkg::BYTE_W-1:0]    first_digit;
  logic [pcd_pkg::BYTE_W-1:0]    first_digit_next;
  logic [pcd_pkg::CNT_W-1:0]     emitted_count;
  logic [pcd_pkg::CNT_W-1:0]     emitted_count_next;

  pcd_pkg::slots_t               d;
  logic [1:0]                    dcnt;
  logic [1:0]                    ecnt;
  logic                          term;
  logic                          plain;
  logic [pcd_pkg::BYTE_W-1:0]    v;
  logic [pcd_pkg::CNT_W-1:0]     avail;

  always_comb begin
    d                = '0;
    dcnt             = 2'd0;
    term             = 1'b0;
    plain            = 1'b0;
    stage_next       = stage;
    first_digit_next = first_digit;
    v                = {pcd_pkg::hex_val(first_digit), pcd_pkg::hex_val(in_byte)};
    case (stage)
      pcd_pkg::STAGE_PCT: begin
        if (pcd_pkg::hex_ok(in_byte)) begin
          first_digit_next = in_byte;
          stage_next       = pcd_pkg::STAGE_DIGIT;
        end else begin
          d[0]       = pcd_pkg::PCT_CHAR;
          dcnt       = 2'd1;
          stage_next = pcd_pkg::STAGE_IDLE;
          plain      = 1'b1;
        end
      end
      pcd_pkg::STAGE_DIGIT: begin
        stage_next       = pcd_pkg::STAGE_IDLE;
        first_digit_next = pcd_pkg::NUL_CHAR;
        if (pcd_pkg::hex_ok(in_byte)) begin
          if (v == pcd_pkg::NUL_CHAR || v == pcd_pkg::DOT_CHAR) begin
            d[0] = pcd_pkg::PCT_CHAR;
            d[1] = first_digit;
            d[2] = in_byte;
            dcnt = 2'd3;
          end else begin
            d[0] = v;
            dcnt = 2'd1;
          end
        end else begin
          d[0]  = pcd_pkg::PCT_CHAR;
          d[1]  = first_digit;
          dcnt  = 2'd2;
          plain = 1'b1;
        end
      end
      default: begin
        stage_next = pcd_pkg::STAGE_IDLE;
        plain      = 1'b1;
      end
    endcase

    if (plain) begin
      if (in_byte == pcd_pkg::NUL_CHAR) begin
        term             = 1'b1;
        stage_next       = pcd_pkg::STAGE_IDLE;
        first_digit_next = pcd_pkg::NUL_CHAR;
      end else if (in_byte == pcd_pkg::PCT_CHAR) begin
        stage_next = pcd_pkg::STAGE_PCT;
      end else begin
        d[dcnt] = in_byte;
        dcnt    = dcnt + 2'd1;
      end
    end

    // data beyond the limit is dropped from the tail of the burst
    avail = max_out_len - emitted_count;
    if (emitted_count >= max_out_len) begin
      ecnt = 2'd0;
    end else if (avail >= {{(pcd_pkg::CNT_W-2){1'b0}}, dcnt}) begin
      ecnt = dcnt;
    end else begin
      ecnt = avail[1:0];
    end

    burst.data = d;
    burst.term = term;
    burst.cnt  = ecnt + {1'b0, term};
    if (term) begin
      burst.data[ecnt] = pcd_pkg::NUL_CHAR;
    end

    emitted_count_next = term ? '0
                              : emitted_count + {{(pcd_pkg::CNT_W-2){1'b0}}, ecnt};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage         <= pcd_pkg::STAGE_IDLE;
      first_digit   <= '0;
      emitted_count <= '0;
    end else if (accept) begin
      stage         <= stage_next;
      first_digit   <= first_digit_next;
      emitted_count <= emitted_count_next;
    end
  end

endmodule

[design/percent_escape_decoder.sv]
// Top level of the streaming percent escape decoder.
//
// Input: in_valid/in_stall with in_byte, one text byte per beat; a zero byte
// ends the string. Output: out_valid/out_stall with out_byte and out_last,
// one result per beat; out_last marks the zero terminator of each string.
// Config: cfg_valid/cfg_ready with cfg_data writes max_out_len (reset 1024);
// cfg_ready is always high.
// Each accepted byte is decoded in the same cycle into a burst of zero to
// three results held in a three-slot output queue; the first result shows
// on the outputs in the cycle after the input beat.
// Throughput is one input byte per cycle while each byte yields at most one
// result and out_stall stays low. A byte yielding two or three results
// (broken escapes, literal "%00" and "%2E", the terminator after a flush)
// holds in_stall while the queue drains, since the queue empties one result
// per cycle while out_stall is low.
// A stalled output holds its result and stalls the input once the queue has
// no room for another burst. Reset (rst, synchronous) empties the queue,
// clears the parser state and the byte count, and restores max_out_len.
module percent_escape_decoder (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [pcd_pkg::BYTE_W-1:0]     in_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [pcd_pkg::BYTE_W-1:0]     out_byte,
  output logic                           out_last,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pcd_pkg::CNT_W-1:0]      cfg_data
);

  logic [pcd_pkg::CNT_W-1:0] max_out_len;
  pcd_pkg::pcd_burst_t       burst;
  pcd_pkg::slots_t           q;
  logic [1:0]                rem;
  logic                      qterm;
  logic                      accept;
  logic                      pop;

  assign cfg_ready = 1'b1;
  assign out_valid = (rem != 2'd0);
  assign out_byte  = q[0];
  assign out_last  = qterm && (rem == 2'd1);
  assign pop       = out_valid && !out_stall;
  assign in_stall  = !((rem == 2'd0) || (rem == 2'd1 && !out_stall));
  assign accept    = in_valid && !in_stall;

  pcd_core u_core (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .in_byte     (in_byte),
    .max_out_len (max_out_len),
    .burst       (burst)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      max_out_len <= pcd_pkg::MAX_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_out_len <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rem   <= 2'd0;
      qterm <= 1'b0;
    end else if (accept) begin
      rem   <= burst.cnt;
      qterm <= burst.term;
    end else if (pop) begin
      rem   <= rem - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q <= burst.data;
    end else if (pop) begin
      q <= {pcd_pkg::NUL_CHAR, q[2], q[1]};
    end
  end

endmodule

[tb/percent_escape_decoder_tb.sv]
// Self-checking testbench for percent_escape_decoder: directed table, random strings, idling.
module percent_escape_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pcd_pkg::*;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } result_t;

  typedef struct packed {
    logic [BYTE_W-1:0] din;
    logic              typed;
    logic [1:0]        n_exp;
    logic [BYTE_W-1:0] e0;
    logic [BYTE_W-1:0] e1;
    logic [BYTE_W-1:0] e2;
    logic              term;
  } dir_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [BYTE_W-1:0] in_byte = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [BYTE_W-1:0] out_byte;
  logic              out_last;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CNT_W-1:0]  cfg_data = '0;

  // decoder image
  logic [1:0]        dec_stage = STAGE_IDLE;
  logic [BYTE_W-1:0] dec_digit = '0;
  logic [CNT_W-1:0]  dec_count = '0;
  logic [CNT_W-1:0]  dec_limit = MAX_RESET;

  result_t decoded_q[$];
  result_t burst[$];
  int      mismatch_count = 0;
  int      bytes_accepted = 0;
  int      in_idle_pct = 0;
  int      out_stall_pct = 0;
  int      hold_left = 0;

  localparam int DIR_ROWS = 23;

  // typed = 0: row checked by the predictor only
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{8'h41, 1'b1, 2'd1, 8'h41, NUL_CHAR, NUL_CHAR, 1'b0},
    '{8'hFF, 1'b1, 2'd1, 8'hFF, NUL_CHAR, NUL_CHAR, 1'b0},
    '{8'h01, 1'b1, 2'd1, 8'h01, NUL_CHAR, NUL_CHAR, 1'b0},
    '{PCT_CHAR, 1'b1, 2'd0, NUL_CHAR, NUL_CHAR, NUL_CHAR, 1'b0},
    '{8'h34, 1'b0, 2'd0, NUL_CHAR, NUL_CHAR, NUL_CHAR, 1'b0},
    '{8'h31, 1'b0, 2'd0, NUL_CHAR, NUL_CHAR, NUL_CHAR, 1'b0},
    '{PCT_CHAR, 1'b0, 2'd0, NUL_CHAR, NUL_CHAR, NUL_CHAR, 1'b0},
    '{8'h32, 1'b0, 2'd0, NUL_CHAR, NUL_CHAR, NUL_CHAR, 1'b0},
    '{8'h65, 1'b0, 2'd0, NUL_CHAR, NUL_CHAR, NUL_CHAR, 1'b0},
    '{PCT_CHAR, 1'b1, 2'd0, NUL_CHAR, NUL_CHAR, NUL_CHAR, 1'b0},
    '{8'h30, 1'b1, 2'd0, NUL_CHAR, NUL_CHAR, NUL_CHAR, 1'b0},
    '{8'h30, 1'b1, 2'd3, PCT_CHAR, 8'h30, 8'h30, 1'b0},
    '{PCT_CHAR, 1'b1, 2'd0, NUL_CHAR, NUL_CHAR, NUL_CHAR, 1'b0},
    '{8'h66, 1'b1, 2'd0, NUL_CHAR, NUL_CHAR, NUL_CHAR, 1'b0},
    '{8'h46, 1'b1, 2'd1, 8'hFF, NUL_CHAR, NUL_CHAR, 1'b0},
    '{PCT_CHAR, 1'b1, 2'd0, NUL_CHAR, NUL_CHAR, NUL_CHAR, 1'b0},
    '{8'h67, 1'b1, 2'd2, PCT_CHAR, 8'h67, NUL_CHAR, 1'b0},
    '{PCT_CHAR, 1'b1, 2'd0, NUL_CHAR, NUL_CHAR, NUL_CHAR, 1'b0},
    '{8'h34, 1'b1, 2'd0, NUL_CHAR, NUL_CHAR, NUL_CHAR, 1'b0},
    '{NUL_CHAR, 1'b1, 2'd3, PCT_CHAR, 8'h34, NUL_CHAR, 1'b1},
    '{PCT_CHAR, 1'b1, 2'd0, NUL_CHAR, NUL_CHAR, NUL_CHAR, 1'b0},
    '{NUL_CHAR, 1'b1, 2'd2, PCT_CHAR, NUL_CHAR, NUL_CHAR, 1'b1},
    '{NUL_CHAR, 1'b1, 2'd1, NUL_CHAR, NUL_CHAR, NUL_CHAR, 1'b1}
  };

  percent_escape_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_last  (out_last),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("percent_escape_decoder verification failed");
    $finish;
  end

  function automatic logic is_hex(input logic [BYTE_W-1:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic logic [3:0] nibble(input logic [BYTE_W-1:0] c);
    if (c <= 8'h39) begin
      return c[3:0];
    end
    return c[3:0] + 4'd9;
  endfunction

  function automatic void emit_data(input logic [BYTE_W-1:0] b);
    if (dec_count < dec_limit) begin
      burst.push_back('{data: b, last: 1'b0});
      dec_count++;
    end
  endfunction

  function automatic void plain_byte(input logic [BYTE_W-1:0] b);
    if (b == NUL_CHAR) begin
      burst.push_back('{data: NUL_CHAR, last: 1'b1});
      dec_stage = STAGE_IDLE;
      dec_digit = '0;
      dec_count = '0;
    end else if (b == PCT_CHAR) begin
      dec_stage = STAGE_PCT;
    end else begin
      emit_data(b);
    end
  endfunction

  function automatic void decode_byte(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] d1;
    logic [BYTE_W-1:0] v;
    case (dec_stage)
      STAGE_PCT: begin
        if (is_hex(b)) begin
          dec_digit = b;
          dec_stage = STAGE_DIGIT;
        end else begin
          dec_stage = STAGE_IDLE;
          emit_data(PCT_CHAR);
          plain_byte(b);
        end
      end
      STAGE_DIGIT: begin
        d1 = dec_digit;
        dec_stage = STAGE_IDLE;
        dec_digit = '0;
        if (is_hex(b)) begin
          v = {nibble(d1), nibble(b)};
          if (v == NUL_CHAR || v == DOT_CHAR) begin
            emit_data(PCT_CHAR);
            emit_data(d1);
            emit_data(b);
          end else begin
            emit_data(v);
          end
        end else begin
          emit_data(PCT_CHAR);
          emit_data(d1);
          plain_byte(b);
        end
      end
      default: begin
        dec_stage = STAGE_IDLE;
        plain_byte(b);
      end
    endcase
  endfunction

  // entered and left at a falling edge; valid stays up for the next beat
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (in_stall);
    burst.delete();
    decode_byte(b);
    foreach (burst[k]) decoded_q.push_back(burst[k]);
    bytes_accepted++;
    @(negedge clk);
  endtask

  task automatic send_row(input dir_row_t row);
    logic [BYTE_W-1:0] e [3];
    result_t r;
    e = '{row.e0, row.e1, row.e2};
    send_byte(row.din);
    if (row.typed) begin
      repeat (burst.size()) void'(decoded_q.pop_back());
      for (int k = 0; k < row.n_exp; k++) begin
        r.data = e[k];
        r.last = row.term && (k == row.n_exp - 1);
        decoded_q.push_back(r);
      end
    end
  endtask

  function automatic logic [BYTE_W-1:0] hex_char();
    int v;
    v = $urandom_range(15);
    if (v < 10) begin
      return 8'(8'h30 + v);
    end
    return 8'(($urandom_range(1) ? 8'h61 : 8'h41) + v - 10);
  endfunction

  task automatic send_random_string();
    int len;
    int kind;
    logic [BYTE_W-1:0] c;
    len = $urandom_range(0, 10);
    repeat (len) begin
      kind = $urandom_range(99);
      if (kind < 40) begin
        c = 8'($urandom_range(8'h20, 8'h7E));
        if (c == PCT_CHAR) c = 8'h5F;
        send_byte(c);
      end else if (kind < 70) begin
        send_byte(PCT_CHAR);
        send_byte(hex_char());
        send_byte(hex_char());
      end else if (kind < 78) begin
        // zero or dot value, kept literal
        send_byte(PCT_CHAR);
        if ($urandom_range(1)) begin
          send_byte(8'h30);
          send_byte(8'h30);
        end else begin
          send_byte(8'h32);
          send_byte($urandom_range(1) ? 8'h65 : 8'h45);
        end
      end else if (kind < 88) begin
        send_byte(PCT_CHAR);
        if ($urandom_range(1)) send_byte(hex_char());
        do c = 8'($urandom_range(255)); while (is_hex(c));
        send_byte(c);
      end else begin
        send_byte(8'($urandom_range(255)));
      end
    end
    if ($urandom_range(9) != 0) send_byte(NUL_CHAR);
  endtask

  task automatic drain();
    int guard;
    in_valid <= 1'b0;
    guard = 0;
    while (decoded_q.size() != 0 && guard < 50000) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_limit(input logic [CNT_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    dec_limit = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input int in_idle, input int rx_stall,
                           input logic [CNT_W-1:0] limit, input int n_bytes);
    int target;
    drain();
    write_limit(limit);
    in_idle_pct   = in_idle;
    out_stall_pct = rx_stall;
    target = bytes_accepted + n_bytes;
    while (bytes_accepted < target) send_random_string();
  endtask

  // receiver side
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < out_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (decoded_q.size() == 0) begin
        $error("unexpected beat: out_byte=%h out_last=%b", out_byte, out_last);
        mismatch_count++;
      end else begin
        want = decoded_q.pop_front();
        if (out_byte !== want.data) begin
          $error("out_byte expected %h actual %h", want.data, out_byte);
          mismatch_count++;
        end
        if (out_last !== want.last) begin
          $error("out_last expected %b actual %b", want.last, out_last);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    int start;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[i]) send_row(dir_rows[i]);

    run_phase(0, 0, 13'd4096, 90);
    run_phase(73, 0, 13'd1, 80);
    run_phase(0, 73, 13'($urandom_range(2, 12)), 80);
    run_phase(33, 33, 13'($urandom_range(13, 4096)), 80);

    // long receiver hold-off while bytes keep coming
    drain();
    in_idle_pct   = 0;
    out_stall_pct = 0;
    @(posedge clk);
    hold_left = 250;
    @(negedge clk);
    start = bytes_accepted;
    while (bytes_accepted < start + 40) send_random_string();

    run_phase(0, 0, 13'd3, 80);
    drain();

    if (mismatch_count == 0 && decoded_q.size() == 0) begin
      $display("percent_escape_decoder verification clean");
    end else begin
      if (decoded_q.size() != 0) $error("%0d results never arrived", decoded_q.size());
      $display("percent_escape_decoder verification failed");
    end
    $finish;
  end

endmodule
